// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define RITA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define RITA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/rita_pkg.sv
// package: constants, types and helper functions of the radix converter
`default_nettype none
package rita_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 7;
    // restoring division steps done by one step command
    localparam int DIV_STEPS      = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RST = 6'd10;
    localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    // 'A' minus ten
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd55;

    typedef struct packed {
        logic load;
        logic step;
        logic push;
        logic dec;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic grp_last;
        logic q_zero;
        logic ptr_zero;
        logic out_free;
    } t_sts;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] v);
        logic [RADIX_W-1:0] r;
        r = v;
        if (v < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (v > RADIX_MAX) begin
            r = RADIX_MAX;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS) begin
            c = CHAR_ZERO + {1'b0, d};
        end else begin
            c = CHAR_ALPHA + {1'b0, d};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: design/rita_if.sv
// channel interfaces: number input, digit output, radix write
`default_nettype none
interface rita_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rita_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic       last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

interface rita_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface
`default_nettype wire

// File: design/rita_dp.sv
// datapath: radix register, shared divider, digit buffer and output register
`default_nettype none
module rita_dp
    import rita_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    input  wire logic                  i_cfg_valid,
    input  wire logic [RADIX_W-1:0]    i_cfg_radix,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [CHAR_W-1:0]          o_digit_char,
    output logic                       o_last_digit
);

    localparam int GROUPS = (DATA_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W  = GROUPS * DIV_STEPS;
    localparam int GRP_W  = $clog2(GROUPS);
    localparam int IDX_W  = $clog2(DATA_WIDTH);

    logic [RADIX_W-1:0] r_radix;
    logic [PAD_W-1:0]   r_q;
    logic [RADIX_W-1:0] r_rem;
    logic [GRP_W-1:0]   r_grp;
    logic [IDX_W-1:0]   r_ptr;
    logic [RADIX_W-1:0] r_rd;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic [RADIX_W-1:0] mem [DATA_WIDTH];

    logic [PAD_W-1:0]   div_q;
    logic [RADIX_W-1:0] div_rem;

    // DIV_STEPS restoring steps on the narrow remainder
    always_comb begin
        logic [RADIX_W:0] t;
        div_q   = r_q;
        div_rem = r_rem;
        for (int s = 0; s < DIV_STEPS; s++) begin
            t     = {div_rem, div_q[PAD_W-1]};
            div_q = {div_q[PAD_W-2:0], 1'b0};
            if (t >= {1'b0, r_radix}) begin
                t        = t - {1'b0, r_radix};
                div_q[0] = 1'b1;
            end
            div_rem = t[RADIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RST;
        end else if (i_cfg_valid) begin
            r_radix <= clamp_radix(i_cfg_radix);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp <= '0;
            r_ptr <= '0;
        end else if (i_cmd.load) begin
            r_grp <= '0;
            r_ptr <= '0;
        end else if (i_cmd.step) begin
            r_grp <= r_grp + 1'b1;
        end else if (i_cmd.push) begin
            r_grp <= '0;
            if (r_q != '0) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end else if (i_cmd.dec) begin
            r_ptr <= r_ptr - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q   <= PAD_W'(i_value);
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_q   <= div_q;
            r_rem <= div_rem;
        end else if (i_cmd.push) begin
            r_rem <= '0;
        end
    end

    // digit buffer, least significant digit at address zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_ptr] <= r_rem;
        end
        r_rd <= mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_char <= digit_to_char(r_rd);
            r_last <= (r_ptr == '0);
        end
    end

    assign o_sts.grp_last = (r_grp == GRP_W'(GROUPS - 1));
    assign o_sts.q_zero   = (r_q == '0);
    assign o_sts.ptr_zero = (r_ptr == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

endmodule
`default_nettype wire

// File: design/rita_ctrl.sv
// controller: sequences division, digit storage and digit output
`default_nettype none
module rita_ctrl
    import rita_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_PUSH = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.grp_last) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = i_sts.q_zero ? ST_RD : ST_DIV;
            end
            ST_RD: begin
                // buffer read data is registered into r_rd at the end of this state
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.ptr_zero) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.dec = 1'b1;
                        n_state   = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule
`default_nettype wire

// File: design/radix_integer_to_ascii.sv
// top level: unsigned integer to ascii digits in a programmable radix
//
//  channel  | dir | payload                 | item
//  ---------+-----+-------------------------+-------------------------------
//  i_in     | in  | value [DATA_WIDTH-1:0]  | one number to convert
//  o_out    | out | digit_char [6:0], last  | one character, msd first
//  i_cfg    | in  | radix [5:0]             | new radix, clamped to 2..36
//
//  one number at a time; each digit is worked out in the shared divider in ST_DIV
//  (4 quotient bits a cycle) and stored in ST_PUSH, then is read back from the
//  single-port digit buffer in ST_RD and sent in ST_EMIT
//  i_in is ready only between numbers; the last character may still wait in
//  the output register while the next number converts
//  o_out back-pressure stalls the readout only; i_cfg is always ready
//  synchronous active-low reset: radix 10, no pending output
`default_nettype none
module radix_integer_to_ascii
    import rita_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rita_in_if.sink     i_in,
    rita_out_if.source  o_out,
    rita_cfg_if.sink    i_cfg
);

    t_cmd cmd;
    t_sts sts;

    // the radix register takes every write
    assign i_cfg.ready = 1'b1;

    // state machine: division, store, readout sequencing
    rita_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // divider, digit buffer, output register
    rita_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_value      (i_in.value),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_radix  (i_cfg.radix),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_digit_char (o_out.digit_char),
        .o_last_digit (o_out.last_digit)
    );

endmodule
`default_nettype wire

// File: design/rita_chk.sv
// port checker for the radix converter and its bind
`default_nettype none
`include "assert_macros.svh"
module rita_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [6:0] i_out_char,
    input wire logic       i_out_last
);

    `RITA_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char) && $stable(i_out_last), "stalled character changed")
    `RITA_ASSERT(a_char_set, i_clk, i_rst_n, i_out_valid |-> (i_out_char >= 7'd48 && i_out_char <= 7'd57) || (i_out_char >= 7'd65 && i_out_char <= 7'd90), "character outside digit set")
    `RITA_ASSERT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "number taken while converting")
    `RITA_ASSERT_NR(a_rst_out, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

endmodule

bind radix_integer_to_ascii rita_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.digit_char),
    .i_out_last  (o_out.last_digit)
);
`default_nettype wire

// File: bench/radix_integer_to_ascii_tb.sv
// testbench of the radix converter: directed and random numbers checked by a scoreboard
`default_nettype none

// expected characters of the converted numbers, oldest first
class digit_scoreboard;
    typedef struct packed {
        logic [rita_pkg::CHAR_W-1:0] digit_char;
        logic                        last_digit;
    } char_item_t;

    char_item_t                   chars_due[$];
    logic [rita_pkg::RADIX_W-1:0] radix;
    int unsigned                  errors;
    string                        glyphs;

    function new();
        radix  = 6'd10;
        errors = 0;
        glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    endfunction

    // register write as the block stores it: low 6 bits, held to 2..36
    function void set_radix(logic [rita_pkg::RADIX_W-1:0] code);
        if (code < 6'd2) begin
            radix = 6'd2;
        end else if (code > 6'd36) begin
            radix = 6'd36;
        end else begin
            radix = code;
        end
    endfunction

    // number accepted: queue its digits, most significant first
    function void note_number(logic [31:0] num);
        logic [63:0]                 rest;
        logic [63:0]                 base;
        logic [rita_pkg::CHAR_W-1:0] rev [64];
        int                          cnt;
        byte                         g;
        char_item_t                  item;
        rest = {32'd0, num};
        base = {58'd0, radix};
        cnt  = 0;
        do begin
            g        = glyphs[int'(rest % base)];
            rev[cnt] = g[6:0];
            rest     = rest / base;
            cnt++;
        end while (rest != 0);
        for (int k = cnt - 1; k >= 0; k--) begin
            item.digit_char = rev[k];
            item.last_digit = (k == 0);
            chars_due.push_back(item);
        end
    endfunction

    // character accepted: compare with the oldest expectation
    function void check_char(logic [rita_pkg::CHAR_W-1:0] c, logic last);
        char_item_t e;
        if (chars_due.size() == 0) begin
            $display("%0t: unexpected character, expected none, actual char %0d last %0b",
                     $time, c, last);
            errors++;
        end else begin
            e = chars_due.pop_front();
            if (c !== e.digit_char) begin
                $display("%0t: digit_char mismatch, expected %0d, actual %0d",
                         $time, e.digit_char, c);
                errors++;
            end
            if (last !== e.last_digit) begin
                $display("%0t: last_digit mismatch, expected %0b, actual %0b",
                         $time, e.last_digit, last);
                errors++;
            end
        end
    endfunction

    function int unsigned pending();
        return chars_due.size();
    endfunction
endclass

module radix_integer_to_ascii_tb;
    import rita_pkg::*;

    localparam int DW           = 32;
    // watchdog limit, set with a wide margin over the slowest run
    localparam int CYCLE_LIMIT  = 1000000;
    // longer than one 32-digit number takes to convert, so this catches any stray character
    localparam int DRAIN_CYCLES = 400;
    localparam int IDLE_PCT     = 6;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   cycle_count;

    digit_scoreboard sb;

    rita_in_if #(.DATA_WIDTH(DW)) num_if ();
    rita_out_if                   char_if ();
    rita_cfg_if                   radix_if ();

    radix_integer_to_ascii #(
        .DATA_WIDTH(DW)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (num_if),
        .o_out  (char_if),
        .i_cfg  (radix_if)
    );

    // 20 time unit clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // every input known from time zero
    initial begin
        rst_n           = 1'b0;
        num_if.valid    = 1'b0;
        num_if.value    = '0;
        radix_if.valid  = 1'b0;
        radix_if.radix  = '0;
        char_if.ready   = 1'b0;
        quiet           = 1'b0;
        sb              = new();
    end

    // receiver side: random short stalls, none while quiet
    always @(negedge clk) begin
        char_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // every accepted character goes to the scoreboard
    always @(posedge clk) begin
        if (rst_n && char_if.valid && char_if.ready) begin
            sb.check_char(char_if.digit_char, char_if.last_digit);
        end
    end

    // watchdog: a hung block ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // offer one number, with random gaps in front; returns at the falling edge
    // after the item was taken, valid still high so a next item can follow at once
    task automatic send_number(input logic [DW-1:0] num);
        while (!quiet && ($urandom_range(0, 99) < IDLE_PCT)) begin
            num_if.valid <= 1'b0;
            @(negedge clk);
        end
        num_if.valid <= 1'b1;
        num_if.value <= num;
        @(posedge clk);
        while (!num_if.ready) @(posedge clk);
        sb.note_number(num);
        @(negedge clk);
    endtask

    // radix write, only once every queued character has come out
    task automatic write_radix(input logic [RADIX_W-1:0] code);
        num_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        radix_if.valid <= 1'b1;
        radix_if.radix <= code;
        @(posedge clk);
        while (!radix_if.ready) @(posedge clk);
        sb.set_radix(code);
        @(negedge clk);
        radix_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // random number with a shape picked at random: full width, short,
    // near a power of the radix, or the two extremes
    function automatic logic [DW-1:0] pick_number();
        logic [63:0] p;
        logic [63:0] r;
        int          shape;
        logic [DW-1:0] num;
        shape = $urandom_range(0, 9);
        r     = {58'd0, sb.radix};
        case (shape)
            5: begin
                num = $urandom_range(0, int'(sb.radix) * int'(sb.radix));
            end
            6: begin
                num = $urandom_range(0, 1) ? '1 : '0;
            end
            7: begin
                num = $urandom >> $urandom_range(0, 31);
            end
            8: begin
                // a power of the radix, or one below it, where the digit count steps
                p = 64'd1;
                repeat ($urandom_range(1, 32)) begin
                    if (p * r <= 64'hFFFF_FFFF) begin
                        p = p * r;
                    end
                end
                if ($urandom_range(0, 1) != 0) begin
                    p = p - 64'd1;
                end
                num = p[DW-1:0];
            end
            9: begin
                num = $urandom_range(0, 65535);
            end
            default: begin
                num = $urandom;
            end
        endcase
        return num;
    endfunction

    // one random phase at one radix setting
    task automatic run_phase(input logic [RADIX_W-1:0] code, input int count, input bit calm);
        write_radix(code);
        quiet = calm;
        repeat (count) send_number(pick_number());
        quiet = 1'b0;
    endtask

    initial begin
        logic [RADIX_W-1:0] code;
        // reset held low from time zero, released at a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset radix is ten: zero, single digits, carries, extremes
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'd9);
        send_number(32'd10);
        send_number(32'd99);
        send_number(32'd100);
        send_number(32'hFFFF_FFFF);
        send_number(32'h8000_0000);

        // highest radix: last letter and the first two-digit number
        write_radix(6'd36);
        send_number(32'd35);
        send_number(32'd36);
        send_number(32'hFFFF_FFFF);
        send_number(32'd0);

        // lowest radix: longest output of 32 digits
        write_radix(6'd2);
        send_number(32'd1);
        send_number(32'd2);
        send_number(32'hFFFF_FFFF);

        // out-of-range writes are held to 2 or 36
        write_radix(6'd0);
        send_number(32'd5);
        write_radix(6'd63);
        send_number(32'd35);
        write_radix(6'd37);
        send_number(32'd36);
        write_radix(6'd1);
        send_number(32'd6);

        write_radix(6'd16);
        send_number(32'hDEAD_BEEF);

        // random phases, one of them with no idling on either side
        run_phase(6'd10, 40, 1'b0);
        run_phase(6'd2, 30, 1'b0);
        run_phase(6'd36, 40, 1'b1);
        run_phase(6'd16, 40, 1'b0);
        run_phase(6'd8, 40, 1'b0);
        run_phase(6'd3, 35, 1'b0);
        run_phase(6'd7, 35, 1'b0);
        run_phase(6'd62, 30, 1'b0);
        repeat (5) begin
            code = RADIX_W'($urandom_range(0, 63));
            run_phase(code, 38, 1'b0);
        end

        // drain: everything out, then a wait to catch any stray characters
        num_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
